// ----- sv/gbte_pkg.sv -----
// ============================================================================
// gbte_pkg
// shared types and constants for the gap buffer text editor core
// ============================================================================
package gbte_pkg;

   localparam int CAPACITY_DEF = 4096;
   localparam int WINDOW_DEF   = 10;

   localparam int OPCODE_W = 2;
   localparam int CHAR_W   = 8;
   localparam int COUNT_W  = 13;
   localparam int KIND_W   = 2;
   localparam int VALUE_W  = 13;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_LEFT   = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_RIGHT  = 2'd3;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_DELETED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHAR    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [CHAR_W-1:0]   char_in;
      logic [COUNT_W-1:0]  count;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]  result_kind;
      logic [VALUE_W-1:0] value;
      logic               last;
   } rsp_type;

endpackage

// ----- sv/gbte_ram.sv -----
// ============================================================================
// gbte_ram
// single-port-write, single-port-read character stack memory, registered read
// ============================================================================
module gbte_ram
   import gbte_pkg::*;
#(
   parameter int DEPTH = CAPACITY_DEF
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [CHAR_W-1:0]          wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [CHAR_W-1:0]          rd_data
);

   logic [CHAR_W-1:0] mem [DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/gap_buffer_text_editor_core.sv -----
// ============================================================================
// gap_buffer_text_editor_core
// text buffer with a cursor, kept as two character stacks in block memory
// ============================================================================
// The text lives in two memories: the before stack (characters left of the
// cursor, top next to the cursor) and the after stack (characters right of
// the cursor). One transaction is taken at a time. An insert gives no
// result; an insert into a full buffer is dropped. A delete gives one
// result with the number of characters removed. A cursor move copies one
// character per cycle between the two memories (read one stack, write the
// other in the next cycle), then the window of up to WINDOW characters
// before the cursor is read from the before stack's read port one per
// cycle while the result channel is not stalled, oldest first, or a single
// empty marker is sent when nothing is left of the cursor. A stall on the
// result channel stalls the window walk. Memory contents need no clearing
// after reset.
// ============================================================================
module gap_buffer_text_editor_core
   import gbte_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int WINDOW   = WINDOW_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW  = $clog2(CAPACITY);
   localparam int LW  = $clog2(CAPACITY + 1);
   localparam int WW  = $clog2(WINDOW + 1);
   localparam int CW  = (LW > COUNT_W) ? LW : COUNT_W;
   localparam int MW  = (LW > WW) ? LW : WW;
   localparam logic [LW:0]   CAP_SUM = (LW + 1)'(CAPACITY);
   localparam logic [MW-1:0] WIN_M   = MW'(WINDOW);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEL,
      ST_MOVE,
      ST_WIN_INIT,
      ST_WIN,
      ST_EMPTY
   } state_type;

   state_type          state_ff, state_in;
   logic [LW-1:0]      blen_ff, blen_in;      // before stack length
   logic [LW-1:0]      alen_ff, alen_in;      // after stack length
   logic [LW-1:0]      cnt_ff, cnt_in;        // move steps still to read
   logic               left_ff, left_in;      // move direction
   logic               pend_ff, pend_in;      // move write owed next cycle
   logic [VALUE_W-1:0] del_ff, del_in;        // deleted count
   logic [AW-1:0]      waddr_ff, waddr_in;    // next window read address
   logic [WW-1:0]      wrem_ff, wrem_in;      // window reads still to issue
   logic [WW-1:0]      wload_ff, wload_in;    // window chars still to send
   logic               dpend_ff, dpend_in;    // read data waiting for output
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // memory ports
   logic              b_we, b_re, a_we, a_re;
   logic [AW-1:0]     b_waddr, b_raddr, a_waddr, a_raddr;
   logic [CHAR_W-1:0] b_wdata, a_wdata, b_rdata, a_rdata;

   logic              out_free;
   logic              win_load, win_issue;
   logic [CW-1:0]     count_w, blen_w, alen_w, del_w;
   logic [MW-1:0]     blen_m;
   logic [WW-1:0]     win_n;

   gbte_ram #(
      .DEPTH (CAPACITY)
   ) u_before (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_en   (b_re),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   gbte_ram #(
      .DEPTH (CAPACITY)
   ) u_after (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_en   (a_re),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // output register free to take a new result this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   // clipping helpers, all compared at a common width
   assign count_w = CW'(req_data.count);
   assign blen_w  = CW'(blen_ff);
   assign alen_w  = CW'(alen_ff);
   assign del_w   = (count_w < blen_w) ? count_w : blen_w;
   assign blen_m  = MW'(blen_ff);
   assign win_n   = (blen_m < WIN_M) ? WW'(blen_ff) : WW'(WINDOW);

   // window walk: a read lands in the memory's output register in the next
   // cycle and waits there until the result register can take it
   assign win_load  = (state_ff == ST_WIN) && dpend_ff && out_free;
   assign win_issue = (state_ff == ST_WIN) && (wrem_ff != '0) && (!dpend_ff || win_load);

   always_comb begin
      state_in     = state_ff;
      blen_in      = blen_ff;
      alen_in      = alen_ff;
      cnt_in       = cnt_ff;
      left_in      = left_ff;
      pend_in      = pend_ff;
      del_in       = del_ff;
      waddr_in     = waddr_ff;
      wrem_in      = wrem_ff;
      wload_in     = wload_ff;
      dpend_in     = dpend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      b_we    = 1'b0;
      b_waddr = blen_ff[AW-1:0];
      b_wdata = req_data.char_in;
      b_re    = 1'b0;
      b_raddr = waddr_ff;
      a_we    = 1'b0;
      a_waddr = alen_ff[AW-1:0];
      a_wdata = b_rdata;
      a_re    = 1'b0;
      a_raddr = AW'(alen_ff - LW'(1));

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.opcode)
                  OP_INSERT: begin
                     // dropped when the buffer is full
                     if (((LW + 1)'(blen_ff) + (LW + 1)'(alen_ff)) < CAP_SUM) begin
                        b_we    = 1'b1;
                        blen_in = blen_ff + LW'(1);
                     end
                  end
                  OP_DELETE: begin
                     blen_in  = blen_ff - LW'(del_w);
                     del_in   = VALUE_W'(del_w);
                     state_in = ST_DEL;
                  end
                  OP_LEFT: begin
                     cnt_in   = LW'(del_w);
                     left_in  = 1'b1;
                     pend_in  = 1'b0;
                     state_in = ST_MOVE;
                  end
                  default: begin
                     cnt_in   = LW'((count_w < alen_w) ? count_w : alen_w);
                     left_in  = 1'b0;
                     pend_in  = 1'b0;
                     state_in = ST_MOVE;
                  end
               endcase
            end
         end

         ST_DEL: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.result_kind = KIND_DELETED;
               rsp_in.value       = del_ff;
               rsp_in.last        = 1'b1;
               state_in           = ST_IDLE;
            end
         end

         ST_MOVE: begin
            // pop one stack while the previous pop is pushed on the other
            if (left_ff) begin
               if (pend_ff) begin
                  a_we    = 1'b1;
                  a_wdata = b_rdata;
                  alen_in = alen_ff + LW'(1);
               end
               if (cnt_ff != '0) begin
                  b_re    = 1'b1;
                  b_raddr = AW'(blen_ff - LW'(1));
                  blen_in = blen_ff - LW'(1);
               end
            end else begin
               if (pend_ff) begin
                  b_we    = 1'b1;
                  b_wdata = a_rdata;
                  blen_in = blen_ff + LW'(1);
               end
               if (cnt_ff != '0) begin
                  a_re    = 1'b1;
                  alen_in = alen_ff - LW'(1);
               end
            end
            if (cnt_ff != '0) begin
               cnt_in  = cnt_ff - LW'(1);
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = ST_WIN_INIT;
               end
            end
         end

         ST_WIN_INIT: begin
            if (blen_ff == '0) begin
               state_in = ST_EMPTY;
            end else begin
               waddr_in = AW'(blen_ff - LW'(win_n));
               wrem_in  = win_n;
               wload_in = win_n;
               dpend_in = 1'b0;
               state_in = ST_WIN;
            end
         end

         ST_WIN: begin
            b_re    = win_issue;
            b_raddr = waddr_ff;
            if (win_issue) begin
               waddr_in = waddr_ff + AW'(1);
               wrem_in  = wrem_ff - WW'(1);
               dpend_in = 1'b1;
            end else if (win_load) begin
               dpend_in = 1'b0;
            end
            if (win_load) begin
               rsp_valid_in       = 1'b1;
               rsp_in.result_kind = KIND_CHAR;
               rsp_in.value       = VALUE_W'(b_rdata);
               rsp_in.last        = (wload_ff == WW'(1));
               wload_in           = wload_ff - WW'(1);
               if (wload_ff == WW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.result_kind = KIND_EMPTY;
               rsp_in.value       = '0;
               rsp_in.last        = 1'b1;
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         blen_ff      <= '0;
         alen_ff      <= '0;
         cnt_ff       <= '0;
         left_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         wrem_ff      <= '0;
         wload_ff     <= '0;
         dpend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         blen_ff      <= blen_in;
         alen_ff      <= alen_in;
         cnt_ff       <= cnt_in;
         left_ff      <= left_in;
         pend_ff      <= pend_in;
         wrem_ff      <= wrem_in;
         wload_ff     <= wload_in;
         dpend_ff     <= dpend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      del_ff   <= del_in;
      waddr_ff <= waddr_in;
      rsp_ff   <= rsp_in;
   end

endmodule
